// ----- hw/rtl/crmm_pkg.sv -----
// Shared types and constants for the cell region mean or mode unit.
package crmm_pkg;

   // Pixel levels and field widths
   localparam int PIX_W         = 8;
   localparam int LEVELS        = 256;
   localparam int CNT_W         = 16;
   localparam int SUM_W         = 24;
   localparam int VAL_W         = 16;
   localparam int QUO_STEP_W    = $clog2(VAL_W);
   localparam int DEF_MAX_CELLS = 256;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // Opcodes
   localparam logic [1:0] OP_ACC   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Register indexes of the csr port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_MODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CELLS = 1'b1;
   localparam logic [CSR_DATA_W-1:0] ACTIVE_CELLS_RST = 9'd256;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BAD_ID = 2'd1,
      STATUS_SAT    = 2'd2
   } status_type;

   // One row of the per-cell store
   typedef struct packed {
      logic [CNT_W-1:0] best;
      logic [PIX_W-1:0] maj;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } cell_entry_type;

endpackage

// ----- hw/rtl/cell_region_mean_or_mode_unit.sv -----
// Per-cell mean or majority pooling of 8-bit pixels held in two on-chip memories.
//
// Input channel req_*: valid/ready, one item per opcode (accumulate a pixel into a
// cell, read a cell, clear all stores). Result channel rsp_*: valid/ready, exactly
// one item per input item, in order. csr_*: write-only port for pool_mode (index 0)
// and active_cells (index 1); write only while no item is in flight.
//
// Timing: an accepted item reads the cell row and the histogram bin, updates and
// writes both back in S_LOOK, and its result passes through S_FINISH into the output
// register. In mean mode a cell with pixels adds a restoring divider (one quotient
// bit per cycle) in S_DIV before S_FINISH. The block takes one item at a time; the
// next one is accepted the cycle after the result register is loaded, even while
// that result still waits for rsp_ready.
//
// Clear sweeps both memories one entry per cycle over all MAX_CELLS*256 bin
// addresses (65536 at the default size), then the result follows. Reset runs the
// same sweep with no result; req_ready stays low until it ends, csr writes are
// taken throughout. A stalled receiver holds the output register; the engine
// then waits in its finish step until the register frees.
module cell_region_mean_or_mode_unit
   import crmm_pkg::*;
#(
   parameter int MAX_CELLS = DEF_MAX_CELLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [7:0]            req_cell_id,
   input  logic [PIX_W-1:0]      req_pixel_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VAL_W-1:0]      rsp_cell_value,
   output logic [CNT_W-1:0]      rsp_pixel_count,
   output logic [1:0]            rsp_status,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CELL_W    = $clog2(MAX_CELLS);
   localparam int BIN_AW    = CELL_W + PIX_W;
   localparam int BIN_DEPTH = MAX_CELLS * LEVELS;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_DIV,
      S_FINISH
   } state_type;

   // Memories
   logic [CNT_W-1:0] bin_mem [BIN_DEPTH];
   cell_entry_type   cell_mem [MAX_CELLS];

   logic                  bin_we;
   logic [BIN_AW-1:0]     bin_waddr;
   logic [CNT_W-1:0]      bin_wdata;
   logic [BIN_AW-1:0]     bin_raddr;
   logic [CNT_W-1:0]      bin_rd_ff;
   logic                  cell_we;
   logic [CELL_W-1:0]     cell_waddr;
   cell_entry_type        cell_wdata;
   logic [CELL_W-1:0]     cell_raddr;
   cell_entry_type        cell_rd_ff;

   // Control and payload registers
   state_type             state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;
   logic [PIX_W-1:0]      pix_ff, pix_in;
   logic                  bad_ff, bad_in;
   logic                  clr_reply_ff, clr_reply_in;
   logic [BIN_AW-1:0]     sweep_ff, sweep_in;
   logic [QUO_STEP_W-1:0] step_ff, step_in;
   logic [VAL_W-1:0]      div_nq_ff, div_nq_in;
   logic [CNT_W-1:0]      div_rem_ff, div_rem_in;
   logic [CNT_W-1:0]      div_den_ff, div_den_in;
   logic [VAL_W-1:0]      res_value_ff, res_value_in;
   logic [CNT_W-1:0]      res_count_ff, res_count_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  pool_mode_ff, pool_mode_in;
   logic [CSR_DATA_W-1:0] active_cells_ff, active_cells_in;

   // Datapath helpers
   logic                  sat;
   logic                  acc_go;
   logic [CNT_W-1:0]      bin_new;
   cell_entry_type        upd;
   cell_entry_type        eff;
   logic [CNT_W:0]        div_shift;
   logic [CNT_W:0]        div_diff;
   logic                  div_ge;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = rsp_value_ff;
   assign rsp_pixel_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   // Reads follow the request ports; the word read at the accept edge is used in S_LOOK.
   assign cell_raddr = CELL_W'(req_cell_id);
   assign bin_raddr  = {CELL_W'(req_cell_id), req_pixel_value};

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      bin_rd_ff <= bin_mem[bin_raddr];
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   // Accumulate update of the row and bin read for this item
   always_comb begin
      sat     = (cell_rd_ff.count == COUNT_MAX);
      acc_go  = (op_ff == OP_ACC) && !bad_ff && !sat;
      bin_new = bin_rd_ff + CNT_W'(1);
      upd       = cell_rd_ff;
      upd.count = cell_rd_ff.count + CNT_W'(1);
      upd.sum   = cell_rd_ff.sum + SUM_W'(pix_ff);
      if (bin_new > cell_rd_ff.best) begin
         upd.best = cell_rd_ff.best + CNT_W'(1);
         upd.maj  = pix_ff;
      end
      eff = acc_go ? upd : cell_rd_ff;
   end

   // One restoring division step
   always_comb begin
      div_shift = {div_rem_ff, div_nq_ff[VAL_W-1]};
      div_diff  = div_shift - {1'b0, div_den_ff};
      div_ge    = (div_shift >= {1'b0, div_den_ff});
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      cell_in         = cell_ff;
      pix_in          = pix_ff;
      bad_in          = bad_ff;
      clr_reply_in    = clr_reply_ff;
      sweep_in        = sweep_ff;
      step_in         = step_ff;
      div_nq_in       = div_nq_ff;
      div_rem_in      = div_rem_ff;
      div_den_in      = div_den_ff;
      res_value_in    = res_value_ff;
      res_count_in    = res_count_ff;
      res_status_in   = res_status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_value_in    = rsp_value_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_status_in   = rsp_status_ff;
      pool_mode_in    = pool_mode_ff;
      active_cells_in = active_cells_ff;

      bin_we     = 1'b0;
      bin_waddr  = {cell_ff, pix_ff};
      bin_wdata  = bin_new;
      cell_we    = 1'b0;
      cell_waddr = cell_ff;
      cell_wdata = upd;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POOL_MODE:    pool_mode_in    = csr_wdata[0];
            CSR_ACTIVE_CELLS: active_cells_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            bin_we     = 1'b1;
            bin_waddr  = sweep_ff;
            bin_wdata  = '0;
            cell_we    = (sweep_ff < BIN_AW'(MAX_CELLS));
            cell_waddr = sweep_ff[CELL_W-1:0];
            cell_wdata = '0;
            sweep_in   = sweep_ff + BIN_AW'(1);
            if (sweep_ff == BIN_AW'(BIN_DEPTH - 1)) begin
               if (clr_reply_ff) begin
                  res_value_in  = '0;
                  res_count_in  = '0;
                  res_status_in = STATUS_OK;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_opcode;
               cell_in = CELL_W'(req_cell_id);
               pix_in  = req_pixel_value;
               bad_in  = ({1'b0, req_cell_id} >= active_cells_ff) ||
                         (32'(req_cell_id) >= 32'(MAX_CELLS));
               if (req_opcode == OP_CLEAR) begin
                  sweep_in     = '0;
                  clr_reply_in = 1'b1;
                  state_in     = S_CLEAR;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end

         S_LOOK: begin
            bin_we   = acc_go;
            cell_we  = acc_go;
            state_in = S_FINISH;
            if (op_ff != OP_ACC && op_ff != OP_READ) begin
               res_value_in  = '0;
               res_count_in  = '0;
               res_status_in = STATUS_OK;
            end else if (bad_ff) begin
               res_value_in  = '0;
               res_count_in  = '0;
               res_status_in = STATUS_BAD_ID;
            end else begin
               res_count_in  = eff.count;
               res_status_in = sat ? STATUS_SAT : STATUS_OK;
               if (pool_mode_ff) begin
                  res_value_in = {eff.maj, 8'h00};
               end else if (eff.count == '0) begin
                  res_value_in = '0;
               end else begin
                  // Dividend is sum << 8; its upper half is always below the count.
                  div_rem_in = eff.sum[SUM_W-1:PIX_W];
                  div_nq_in  = {eff.sum[PIX_W-1:0], 8'h00};
                  div_den_in = eff.count;
                  step_in    = '0;
                  state_in   = S_DIV;
               end
            end
         end

         S_DIV: begin
            div_rem_in = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
            div_nq_in  = {div_nq_ff[VAL_W-2:0], div_ge};
            step_in    = step_ff + QUO_STEP_W'(1);
            if (step_ff == QUO_STEP_W'(VAL_W - 1)) begin
               res_value_in = {div_nq_ff[VAL_W-2:0], div_ge};
               state_in     = S_FINISH;
            end
         end

         S_FINISH: begin
            // Hold until the output register frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_count_in  = res_count_ff;
               rsp_status_in = res_status_ff;
               clr_reply_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         sweep_ff        <= '0;
         clr_reply_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pool_mode_ff    <= 1'b0;
         active_cells_ff <= ACTIVE_CELLS_RST;
      end else begin
         state_ff        <= state_in;
         sweep_ff        <= sweep_in;
         clr_reply_ff    <= clr_reply_in;
         rsp_valid_ff    <= rsp_valid_in;
         pool_mode_ff    <= pool_mode_in;
         active_cells_ff <= active_cells_in;
      end
      op_ff         <= op_in;
      cell_ff       <= cell_in;
      pix_ff        <= pix_in;
      bad_ff        <= bad_in;
      step_ff       <= step_in;
      div_nq_ff     <= div_nq_in;
      div_rem_ff    <= div_rem_in;
      div_den_ff    <= div_den_in;
      res_value_ff  <= res_value_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ----- hw/rtl/crmm_checker.sv -----
// Port-level checks for the cell region mean or mode unit, bound to the top level.
module crmm_checker
   import crmm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [VAL_W-1:0] rsp_cell_value,
   input logic [CNT_W-1:0] rsp_pixel_count,
   input logic [1:0]       rsp_status
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value) &&
      $stable(rsp_pixel_count) && $stable(rsp_status))
      else $error("stalled result changed");

   // One item at a time: an accept drops ready
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while busy");

   // An empty cell has a zero statistic in both modes
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_count == '0 |-> rsp_cell_value == '0)
      else $error("nonzero value for an empty cell");

   a_bad_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_ID |-> rsp_cell_value == '0 &&
      rsp_pixel_count == '0)
      else $error("rejected cell id returned data");

   a_sat_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_SAT |-> rsp_pixel_count == COUNT_MAX)
      else $error("saturation flagged below full count");

endmodule

bind cell_region_mean_or_mode_unit crmm_checker u_crmm_checker (.*);
